// ===== src/fci_pkg.sv =====
// Shared types and constants of the flash command interface.
package fci_pkg;

  localparam int unsigned FieldAddrBits = 19;
  localparam int unsigned ByteBits      = 8;
  localparam int unsigned CfgIdxBits    = 2;

  localparam logic [ByteBits-1:0] CmdUnlock1 = 8'hAA;
  localparam logic [ByteBits-1:0] CmdUnlock2 = 8'h55;
  localparam logic [ByteBits-1:0] CmdReset   = 8'hF0;
  localparam logic [ByteBits-1:0] CmdAutosel = 8'h90;
  localparam logic [ByteBits-1:0] CmdProgram = 8'hA0;
  localparam logic [ByteBits-1:0] IdManuf    = 8'h01;
  localparam logic [ByteBits-1:0] IdDevice   = 8'hA4;
  localparam logic [ByteBits-1:0] IdZero     = 8'h00;
  localparam logic [ByteBits-1:0] ErasedByte = 8'hFF;

  localparam logic [ByteBits-1:0] IdAddrManuf  = 8'h00;
  localparam logic [ByteBits-1:0] IdAddrDevice = 8'h01;
  localparam logic [ByteBits-1:0] IdAddrZero   = 8'h02;

  localparam logic [FieldAddrBits-1:0] MaskReset   = 19'h007FF;
  localparam logic [FieldAddrBits-1:0] FirstReset  = 19'h00555;
  localparam logic [FieldAddrBits-1:0] SecondReset = 19'h002AA;

  typedef enum logic [1:0] {
    REQ_READ  = 2'd0,
    REQ_WRITE = 2'd1,
    REQ_LOAD  = 2'd2,
    REQ_NONE  = 2'd3
  } req_e;

  typedef enum logic [CfgIdxBits-1:0] {
    CFG_MASK   = 2'd0,
    CFG_FIRST  = 2'd1,
    CFG_SECOND = 2'd2,
    CFG_UNUSED = 2'd3
  } cfg_idx_e;

  typedef enum logic [2:0] {
    MODE_READ    = 3'd0,
    MODE_UNLOCK1 = 3'd1,
    MODE_UNLOCK2 = 3'd2,
    MODE_AUTOSEL = 3'd3,
    MODE_PROGRAM = 3'd4,
    MODE_PROGERR = 3'd5
  } mode_e;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC
  } state_e;

  typedef struct packed {
    logic [FieldAddrBits-1:0] mask;
    logic [FieldAddrBits-1:0] first;
    logic [FieldAddrBits-1:0] second;
  } cfg_t;

  typedef struct packed {
    mode_e                mode_next;
    logic                 failed;
    logic                 prog_we;
    logic [ByteBits-1:0]  prog_byte;
  } cmd_res_t;

endpackage

// ===== src/fci_if.sv =====
// Valid/ready channel interfaces for request and response items.
interface fci_req_if;
  import fci_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [1:0]               req_type;
  logic [FieldAddrBits-1:0] address;
  logic [ByteBits-1:0]      write_data;

  modport source (output valid, req_type, address, write_data, input ready);
  modport sink (input valid, req_type, address, write_data, output ready);
endinterface

interface fci_rsp_if;
  import fci_pkg::*;
  logic                valid;
  logic                ready;
  logic [ByteBits-1:0] read_data;
  logic [2:0]          mode_after;
  logic                program_failed;

  modport source (output valid, read_data, mode_after, program_failed, input ready);
  modport sink (input valid, read_data, mode_after, program_failed, output ready);
endinterface

// ===== src/fci_ram.sv =====
// Generic single-port RAM with registered read data.
module fci_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem_q[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/fci_cmd.sv =====
// Command sequencer: mode registers and the unlock and program decoder.
module fci_cmd import fci_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     step_i,
  input  cfg_t                     cfg_i,
  input  logic [FieldAddrBits-1:0] address_i,
  input  logic [ByteBits-1:0]      data_i,
  input  logic [ByteBits-1:0]      stored_i,
  output mode_e                    mode_o,
  output cmd_res_t                 res_o
);

  mode_e mode_q, mode_d;
  logic  base_as_q, base_as_d;
  logic  hit_first, hit_second;
  mode_e base_mode;
  logic [ByteBits-1:0] anded;

  assign hit_first  = (address_i & cfg_i.mask) == cfg_i.first;
  assign hit_second = (address_i & cfg_i.mask) == cfg_i.second;
  assign base_mode  = base_as_q ? MODE_AUTOSEL : MODE_READ;
  assign anded      = stored_i & data_i;

  always_comb begin
    mode_d    = mode_q;
    base_as_d = base_as_q;
    unique case (mode_q)
      MODE_READ: begin
        if (hit_first && data_i == CmdUnlock1) mode_d = MODE_UNLOCK1;
      end
      MODE_UNLOCK1: begin
        if (hit_second && data_i == CmdUnlock2) mode_d = MODE_UNLOCK2;
        else mode_d = base_mode;
      end
      MODE_UNLOCK2: begin
        if (hit_first && data_i == CmdReset) begin
          mode_d    = MODE_READ;
          base_as_d = 1'b0;
        end else if (hit_first && data_i == CmdAutosel) begin
          mode_d    = MODE_AUTOSEL;
          base_as_d = 1'b1;
        end else if (hit_first && data_i == CmdProgram) begin
          mode_d = MODE_PROGRAM;
        end else begin
          mode_d = base_mode;
        end
      end
      MODE_PROGRAM: begin
        if (anded != data_i) mode_d = MODE_PROGERR;
        else mode_d = base_mode;
      end
      MODE_AUTOSEL, MODE_PROGERR: begin
        if (hit_first && data_i == CmdUnlock1) begin
          mode_d = MODE_UNLOCK1;
        end else if (data_i == CmdReset) begin
          mode_d    = MODE_READ;
          base_as_d = 1'b0;
        end
      end
      default: mode_d = base_mode;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= MODE_READ;
      base_as_q <= 1'b0;
    end else if (step_i) begin
      mode_q    <= mode_d;
      base_as_q <= base_as_d;
    end
  end

  assign mode_o          = mode_q;
  assign res_o.mode_next = mode_d;
  assign res_o.prog_we   = mode_q == MODE_PROGRAM;
  assign res_o.failed    = (mode_q == MODE_PROGRAM) && (anded != data_i);
  assign res_o.prog_byte = anded;

endmodule

// ===== src/flash_command_interface_core.sv =====
// Top level of the flash command interface: item control, array and config registers.
// The array read for an item is issued at acceptance in IDLE; EXEC then decodes, writes
// the array back for load and program items and loads the output register when free.
// The single array port is shared by read and write-back, and a new item is accepted
// only in IDLE, after the current one has left EXEC.
// After reset, a clearing pass writes 0xFF to every byte before any item is taken.
module flash_command_interface_core import fci_pkg::*; #(
  parameter int unsigned ADDR_BITS = 19
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  fci_req_if.sink                   in_ch,
  fci_rsp_if.source                 out_ch,
  input  logic                      cfg_we_i,
  input  logic [CfgIdxBits-1:0]     cfg_idx_i,
  input  logic [FieldAddrBits-1:0]  cfg_data_i
);

  state_e state_q, state_d;
  logic [ADDR_BITS-1:0] clr_cnt_q;
  logic clr_last;

  cfg_t cfg_q;

  req_e                     item_req_q;
  logic [FieldAddrBits-1:0] item_addr_q;
  logic [ByteBits-1:0]      item_data_q;

  logic                out_valid_q;
  logic [ByteBits-1:0] out_rd_q;
  mode_e               out_mode_q;
  logic                out_fail_q;

  logic in_fire, exec_fire;
  logic ram_en, ram_we;
  logic [ADDR_BITS-1:0] ram_addr;
  logic [ByteBits-1:0]  ram_wdata, ram_rdata;

  mode_e    mode_cur;
  cmd_res_t cmd_res;
  logic [ByteBits-1:0] rd_val;

  assign clr_last  = &clr_cnt_q;
  assign in_fire   = in_ch.valid && in_ch.ready;
  assign exec_fire = (state_q == ST_EXEC) && (!out_valid_q || out_ch.ready);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: if (clr_last) state_d = ST_IDLE;
      ST_IDLE:  if (in_ch.valid) state_d = ST_EXEC;
      ST_EXEC:  if (exec_fire) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ch.ready = 1'b0;
    ram_en      = 1'b0;
    ram_we      = 1'b0;
    ram_addr    = ADDR_BITS'(item_addr_q);
    ram_wdata   = item_data_q;
    unique case (state_q)
      ST_CLEAR: begin
        ram_en    = 1'b1;
        ram_we    = 1'b1;
        ram_addr  = clr_cnt_q;
        ram_wdata = ErasedByte;
      end
      ST_IDLE: begin
        in_ch.ready = 1'b1;
        ram_en      = in_ch.valid;
        ram_addr    = ADDR_BITS'(in_ch.address);
      end
      ST_EXEC: begin
        if (item_req_q == REQ_LOAD) begin
          ram_en = exec_fire;
          ram_we = 1'b1;
        end else if (item_req_q == REQ_WRITE && cmd_res.prog_we) begin
          ram_en    = exec_fire;
          ram_we    = 1'b1;
          ram_wdata = cmd_res.prog_byte;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      clr_cnt_q <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_CLEAR) clr_cnt_q <= clr_cnt_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mask   <= MaskReset;
      cfg_q.first  <= FirstReset;
      cfg_q.second <= SecondReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_MASK:   cfg_q.mask   <= cfg_data_i;
        CFG_FIRST:  cfg_q.first  <= cfg_data_i;
        CFG_SECOND: cfg_q.second <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      item_req_q  <= req_e'(in_ch.req_type);
      item_addr_q <= in_ch.address;
      item_data_q <= in_ch.write_data;
    end
  end

  fci_ram #(
    .Width (ByteBits),
    .Depth (2 ** ADDR_BITS)
  ) u_array (
    .clk_i   (clk_i),
    .en_i    (ram_en),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  fci_cmd u_cmd (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (exec_fire && item_req_q == REQ_WRITE),
    .cfg_i     (cfg_q),
    .address_i (item_addr_q),
    .data_i    (item_data_q),
    .stored_i  (ram_rdata),
    .mode_o    (mode_cur),
    .res_o     (cmd_res)
  );

  always_comb begin
    rd_val = ram_rdata;
    if (mode_cur == MODE_AUTOSEL) begin
      case (item_addr_q[ByteBits-1:0])
        IdAddrManuf:  rd_val = IdManuf;
        IdAddrDevice: rd_val = IdDevice;
        IdAddrZero:   rd_val = IdZero;
        default:      rd_val = ram_rdata;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (exec_fire) begin
      out_valid_q <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (exec_fire) begin
      out_rd_q   <= (item_req_q == REQ_READ) ? rd_val : '0;
      out_mode_q <= (item_req_q == REQ_WRITE) ? cmd_res.mode_next : mode_cur;
      out_fail_q <= (item_req_q == REQ_WRITE) && cmd_res.failed;
    end
  end

  assign out_ch.valid          = out_valid_q;
  assign out_ch.read_data      = out_rd_q;
  assign out_ch.mode_after     = out_mode_q;
  assign out_ch.program_failed = out_fail_q;

endmodule
